@@ design/row_column_score_sort_order_core_defines.svh @@
// assertion macros for the row/column score ordering core
// no dependencies; included by rcso_ctrl, the module that carries checks
`ifndef ROW_COLUMN_SCORE_SORT_ORDER_CORE_DEFINES_SVH
`define ROW_COLUMN_SCORE_SORT_ORDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define RCSO_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcso check failed");

// antecedent implies consequent in the next cycle
`define RCSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcso check failed");

`else

`define RCSO_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RCSO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ design/rcso_pkg.sv @@
// shared types, constants and the ordering compare for the score ordering core
// no dependencies
package rcso_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int COST_BITS_DEF = 16;

  localparam int IDX_W   = 6;
  localparam int COST_W  = 16;
  localparam int SCORE_W = 23;
  localparam int SUM_W   = SCORE_W + 1;
  localparam int N_W     = 7;

  localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((2 ** (SCORE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_W'(2 ** (SCORE_W - 1));

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ACCUM,
    OP_SORT,
    OP_SHIFT,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     odd;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [COST_W-1:0] cost;
    logic              hit;
    logic [N_W-1:0]    n;
  } upd_t;

  typedef struct packed {
    logic                      valid;
    logic [IDX_W-1:0]          idx;
    logic signed [SCORE_W-1:0] score;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{valid: 1'b0, idx: '0, score: '0};

  // true when a must leave before b: higher score first, lower index on a tie
  function automatic logic goes_before(cell_t a, cell_t b);
    logic gt;
    logic eq;
    gt = $signed(a.score) > $signed(b.score);
    eq = a.score == b.score;
    return a.valid && (!b.valid || gt || (eq && (a.idx < b.idx)));
  endfunction

endpackage

@@ design/rcso_cell.sv @@
// one score cell: accumulates its item's score, swaps with neighbors, shifts out
// depends on rcso_pkg
module rcso_cell
  import rcso_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  ctl,
  input  upd_t  upd,
  input  cell_t left_i,
  input  cell_t right_i,
  input  logic  swap_left,
  input  logic  swap_right,
  output cell_t data_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(POS);

  cell_t data_r;
  cell_t data_nxt;

  logic                    add_hit;
  logic                    sub_hit;
  logic signed [SUM_W-1:0] cost_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [SCORE_W-1:0] sat;

  always_comb begin
    add_hit  = upd.hit && (upd.row == MY_IDX);
    sub_hit  = upd.hit && (upd.col == MY_IDX);
    cost_ext = $signed({{(SUM_W - COST_W){1'b0}}, upd.cost});
    sum      = $signed({data_r.score[SCORE_W-1], data_r.score});
    if (add_hit) begin
      sum = sum + cost_ext;
    end else if (sub_hit) begin
      sum = sum - cost_ext;
    end
    if (sum > SUM_HI) begin
      sat = SUM_HI[SCORE_W-1:0];
    end else if (sum < SUM_LO) begin
      sat = SUM_LO[SCORE_W-1:0];
    end else begin
      sat = sum[SCORE_W-1:0];
    end
  end

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_ACCUM: begin
        data_nxt.valid = N_W'(POS) < upd.n;
        data_nxt.score = sat;
      end
      OP_SORT: begin
        if (swap_right) begin
          data_nxt = right_i;
        end else if (swap_left) begin
          data_nxt = left_i;
        end
      end
      OP_SHIFT: data_nxt = right_i;
      OP_CLEAR: data_nxt = '{valid: 1'b0, idx: MY_IDX, score: '0};
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '{valid: 1'b0, idx: MY_IDX, score: '0};
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data_o = data_r;

endmodule

@@ design/rcso_ctrl.sv @@
// sequencer for the score ordering core: load, sort passes, emission
// depends on rcso_pkg and the assertion macro header
`include "row_column_score_sort_order_core_defines.svh"

module rcso_ctrl
  import rcso_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  logic           out_ready,
  input  logic [N_W-1:0] n,
  output logic           in_ready,
  output logic           out_valid,
  output logic           out_last,
  output ctl_t           ctl
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] phase_r;
  logic [CNT_W-1:0] phase_nxt;
  logic [CNT_W-1:0] emit_r;
  logic [CNT_W-1:0] emit_nxt;
  logic             in_fire;
  logic             out_fire;

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_EMIT;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign out_last  = N_W'(emit_r) == (n - N_W'(1));

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    emit_nxt  = emit_r;
    ctl.op    = OP_HOLD;
    ctl.odd   = phase_r[0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ctl.op = OP_ACCUM;
          if (in_last) begin
            state_nxt = ST_SORT;
            phase_nxt = '0;
          end
        end
      end
      ST_SORT: begin
        ctl.op    = OP_SORT;
        phase_nxt = phase_r + CNT_W'(1);
        if (phase_r == CNT_W'(MAX_ITEMS - 1)) begin
          state_nxt = ST_EMIT;
          emit_nxt  = '0;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          if (out_last) begin
            ctl.op    = OP_CLEAR;
            state_nxt = ST_IDLE;
          end else begin
            ctl.op   = OP_SHIFT;
            emit_nxt = emit_r + CNT_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      emit_r  <= emit_nxt;
    end
  end

  `RCSO_ASSERT_SAME(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  `RCSO_ASSERT_NEXT(a_last_starts_sort, clk, rst_n, in_fire && in_last, ctl.op == OP_SORT)
  `RCSO_ASSERT_NEXT(a_final_frees_input, clk, rst_n, out_fire && out_last, in_ready)
  `RCSO_ASSERT_SAME(a_emit_in_range, clk, rst_n, out_valid, N_W'(emit_r) < n)

endmodule

@@ design/row_column_score_sort_order_core.sv @@
// row/column score ordering core: chain of score cells plus sequencer
// depends on rcso_pkg, rcso_cell and rcso_ctrl
//
//  port group  | dir | payload
//  ------------+-----+------------------------------------------------------
//  in_*        | in  | tdata: row_index, column_index, cost_value; tlast: last_entry
//  out_*       | out | tdata: item_index, item_score; tlast: last_in_order
//  cfg_*       | in  | wr_data: item_count
//
// one matrix entry request per cycle while loading; every cell compares the
// row and column against its own position and updates its score in place
// after the last entry: odd-even transposition passes between neighboring
// cells, then one result per cycle shifted out of cell 0
// (slower under out_tready stalls); the final accept clears all cells
// in_tready is low from the last entry until the final result is taken
// synchronous active-low reset: scores zero, item_count 64
module row_column_score_sort_order_core
  import rcso_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // entry request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index[5:0], column_index[11:6], cost_value[27:12]
  input  logic        in_tlast,   // last_entry
  // ordering result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // item_index[5:0], item_score[28:6]
  output logic        out_tlast,  // last_in_order
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data // item_count
);

  // low COST_BITS bits of the cost field take part
  localparam logic [COST_W-1:0] COST_MASK = (COST_BITS >= COST_W) ? {COST_W{1'b1}} :
    COST_W'((64'(1) << COST_BITS) - 64'(1));

  logic [N_W-1:0] item_count_r;
  logic [N_W-1:0] live_n;
  ctl_t           ctl;
  upd_t           upd;
  logic           out_last_w;

  cell_t                cells [MAX_ITEMS];
  logic [MAX_ITEMS-2:0] swap;

  // item_count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= N_W'(64);
    end else if (cfg_wr_en) begin
      item_count_r <= cfg_wr_data;
    end
  end

  // clamp to 1..MAX_ITEMS
  always_comb begin
    if (item_count_r == '0) begin
      live_n = N_W'(1);
    end else if (item_count_r > N_W'(MAX_ITEMS)) begin
      live_n = N_W'(MAX_ITEMS);
    end else begin
      live_n = item_count_r;
    end
  end

  // broadcast update: off-diagonal entries inside the instance only
  always_comb begin
    upd.row  = in_tdata[5:0];
    upd.col  = in_tdata[11:6];
    upd.cost = in_tdata[27:12] & COST_MASK;
    upd.n    = live_n;
    upd.hit  = (upd.row != upd.col) && ({1'b0, upd.row} < live_n) &&
               ({1'b0, upd.col} < live_n);
  end

  rcso_ctrl #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .out_ready(out_tready),
    .n        (live_n),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_last (out_last_w),
    .ctl      (ctl)
  );

  // neighbor compare-exchange, even boundaries on even passes, odd on odd
  for (genvar b = 0; b < MAX_ITEMS - 1; b++) begin : g_swap
    localparam logic PAR = logic'(b % 2);
    assign swap[b] = (ctl.op == OP_SORT) && (ctl.odd == PAR) &&
                     goes_before(cells[b+1], cells[b]);
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_t left_w;
    cell_t right_w;
    logic  swap_l;
    logic  swap_r;

    if (i == 0) begin : g_head
      assign left_w = CELL_EMPTY;
      assign swap_l = 1'b0;
    end else begin : g_body_l
      assign left_w = cells[i-1];
      assign swap_l = swap[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_w = CELL_EMPTY;
      assign swap_r  = 1'b0;
    end else begin : g_body_r
      assign right_w = cells[i+1];
      assign swap_r  = swap[i];
    end

    rcso_cell #(
      .POS(i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .upd       (upd),
      .left_i    (left_w),
      .right_i   (right_w),
      .swap_left (swap_l),
      .swap_right(swap_r),
      .data_o    (cells[i])
    );
  end

  // cell 0 holds the result at the head of the ordering
  assign out_tdata = {3'b000, cells[0].score, cells[0].idx};
  assign out_tlast = out_last_w;

endmodule
